### rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GASP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define GASP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### rtl/gasp_pkg.sv
// ----------------------------------------------------------------------------
// gasp_pkg
// Types, codes and helpers shared by the glyph atlas shelf packer modules.
// ----------------------------------------------------------------------------
package gasp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] STATUS_PLACED  = 2'd0;
    localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    localparam logic [1:0] CFG_INITIAL_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAX_SIZE     = 2'd1;
    localparam logic [1:0] CFG_PADDING      = 2'd2;

    localparam logic [3:0] LOG2_MIN = 4'd4;
    localparam logic [3:0] LOG2_MAX = 4'd13;

    typedef struct packed {
        logic [9:0] key;
        logic [9:0] h;
        logic [9:0] w;
    } glyph_entry_t;

    typedef struct packed {
        logic         last;
        glyph_entry_t entry;
    } glyph_item_t;

    function automatic logic [3:0] clamp_log2(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < LOG2_MIN) r = LOG2_MIN;
        if (v > LOG2_MAX) r = LOG2_MAX;
        return r;
    endfunction

endpackage

### rtl/gasp_front.sv
// ----------------------------------------------------------------------------
// gasp_front
// Input side: accepts glyph transfers and queues them for the packing engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gasp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // glyph_width, glyph_height, sort_height
    input  logic                 s_tlast,
    output logic                 q_valid,
    output gasp_pkg::glyph_item_t q_item,
    input  logic                 q_pop
);

    localparam int PW = $clog2(gasp_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(gasp_pkg::QUEUE_DEPTH + 1);

    gasp_pkg::glyph_item_t   queue_mem [gasp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]           count_reg;
    logic                    push, pop;
    gasp_pkg::glyph_item_t   in_item;

    assign s_tready = count_reg != CW'(gasp_pkg::QUEUE_DEPTH);
    assign q_valid  = count_reg != '0;
    assign q_item   = queue_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        in_item.last      = s_tlast;
        in_item.entry.w   = s_tdata[9:0];
        in_item.entry.h   = s_tdata[19:10];
        in_item.entry.key = s_tdata[29:20];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    `GASP_ASSERT(a_count_bound, count_reg <= CW'(gasp_pkg::QUEUE_DEPTH), "queue overfilled")
    `GASP_ASSERT(a_count_track, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1),
        "queue count lost a push")

endmodule

### rtl/gasp_back.sv
// ----------------------------------------------------------------------------
// gasp_back
// Packing engine: stores glyphs, ranks them by key, shelf-packs with retries
// at doubled edge sizes and returns one result per stored glyph in arrival order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gasp_back #(
    parameter int MAX_GLYPHS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  gasp_pkg::glyph_item_t q_item,
    output logic                  q_pop,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [3:0]            cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int IW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CW = $clog2(MAX_GLYPHS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_G_RD, S_G_LAT, S_J_RD, S_J_CMP, S_R_WR,
        S_P_START, S_P_ORD, S_P_ENT, S_P_BRK, S_P_FIT,
        S_E_START, S_E_RD, S_E_LOAD, S_E_WAIT
    } state_t;

    gasp_pkg::glyph_entry_t store_mem [MAX_GLYPHS];
    logic [IW-1:0]          order_mem [MAX_GLYPHS];
    logic [25:0]            pos_mem   [MAX_GLYPHS];

    state_t                 state_reg;
    logic [CW-1:0]          total_reg;
    logic                   dropped_reg;
    logic [3:0]             cur_lg_reg, max_lg_reg, pad_reg, lg_reg;
    logic [IW-1:0]          g_reg, j_reg, i_reg, cnt_reg;
    logic [9:0]             keyg_reg;
    logic [14:0]            cx_reg, cy_reg, row_reg;
    logic [10:0]            w_reg, h_reg;
    logic                   ok_reg;
    gasp_pkg::glyph_entry_t store_rd_reg;
    logic [IW-1:0]          order_rd_reg;
    logic [25:0]            pos_rd_reg;
    logic                   m_valid_reg, m_last_reg;
    logic [1:0]             m_status_reg;
    logic [5:0]             m_num_reg;
    logic [12:0]            m_x_reg, m_y_reg;
    logic [13:0]            m_size_reg;

    logic [IW-1:0]          store_rd_addr;
    logic                   store_wr;
    logic [CW-1:0]          n_last;
    logic [4:0]             pad2;
    logic [10:0]            w_pad, h_pad;
    logic [14:0]            size;
    logic [3:0]             maxl, start_lg;
    logic                   brk, fit_fail;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign store_wr = q_pop && (total_reg < CW'(MAX_GLYPHS));
    assign n_last   = total_reg - 1'b1;
    assign pad2     = {pad_reg, 1'b0};
    assign w_pad    = 11'(store_rd_reg.w) + 11'(pad2);
    assign h_pad    = 11'(store_rd_reg.h) + 11'(pad2);
    assign size     = 15'(1) << lg_reg;
    assign maxl     = gasp_pkg::clamp_log2(max_lg_reg);
    assign start_lg = (gasp_pkg::clamp_log2(cur_lg_reg) > maxl) ? maxl
                                                              : gasp_pkg::clamp_log2(cur_lg_reg);
    assign brk      = (cx_reg + 15'(w_pad)) >= size;
    assign fit_fail = (15'(w_reg) > size) || ((cy_reg + 15'(h_reg)) > size);

    always_comb begin
        unique case (state_reg)
            S_G_RD:  store_rd_addr = g_reg;
            S_J_RD:  store_rd_addr = j_reg;
            default: store_rd_addr = order_rd_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[total_reg[IW-1:0]] <= q_item.entry;
        end
        store_rd_reg <= store_mem[store_rd_addr];
        if (state_reg == S_R_WR) begin
            order_mem[cnt_reg] <= g_reg;
        end
        order_rd_reg <= order_mem[i_reg];
        if (state_reg == S_P_FIT && !fit_fail) begin
            pos_mem[order_rd_reg] <= {13'(cy_reg + 15'(pad_reg)), 13'(cx_reg + 15'(pad_reg))};
        end
        pos_rd_reg <= pos_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            dropped_reg <= 1'b0;
            cur_lg_reg  <= 4'd8;
            max_lg_reg  <= 4'd13;
            pad_reg     <= 4'd2;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    gasp_pkg::CFG_INITIAL_SIZE: cur_lg_reg <= cfg_data;
                    gasp_pkg::CFG_MAX_SIZE:     max_lg_reg <= cfg_data;
                    gasp_pkg::CFG_PADDING:      pad_reg    <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        if (store_wr) total_reg <= total_reg + 1'b1;
                        else dropped_reg <= 1'b1;
                        if (q_item.last) begin
                            g_reg     <= '0;
                            state_reg <= S_G_RD;
                        end
                    end
                end
                S_G_RD: begin
                    state_reg <= (total_reg == '0) ? S_P_START : S_G_LAT;
                end
                S_G_LAT: begin
                    keyg_reg  <= store_rd_reg.key;
                    j_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_J_RD;
                end
                S_J_RD: state_reg <= S_J_CMP;
                S_J_CMP: begin
                    if (store_rd_reg.key > keyg_reg ||
                        (store_rd_reg.key == keyg_reg && j_reg < g_reg)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (CW'(j_reg) == n_last) state_reg <= S_R_WR;
                    else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_J_RD;
                    end
                end
                S_R_WR: begin
                    if (CW'(g_reg) == n_last) state_reg <= S_P_START;
                    else begin
                        g_reg     <= g_reg + 1'b1;
                        state_reg <= S_G_RD;
                    end
                end
                S_P_START: begin
                    lg_reg    <= start_lg;
                    i_reg     <= '0;
                    cx_reg    <= '0;
                    cy_reg    <= '0;
                    row_reg   <= '0;
                    ok_reg    <= 1'b1;
                    state_reg <= (total_reg == '0) ? S_E_START : S_P_ORD;
                end
                S_P_ORD: state_reg <= S_P_ENT;
                S_P_ENT: state_reg <= S_P_BRK;
                S_P_BRK: begin
                    w_reg <= w_pad;
                    h_reg <= h_pad;
                    if (brk) begin
                        cx_reg  <= '0;
                        cy_reg  <= cy_reg + row_reg;
                        row_reg <= '0;
                    end
                    state_reg <= S_P_FIT;
                end
                S_P_FIT: begin
                    if (fit_fail) begin
                        if (lg_reg >= maxl) begin
                            ok_reg    <= 1'b0;
                            state_reg <= S_E_START;
                        end else begin
                            lg_reg    <= lg_reg + 1'b1;
                            i_reg     <= '0;
                            cx_reg    <= '0;
                            cy_reg    <= '0;
                            row_reg   <= '0;
                            state_reg <= S_P_ORD;
                        end
                    end else begin
                        cx_reg <= cx_reg + 15'(w_reg);
                        if (15'(h_reg) > row_reg) row_reg <= 15'(h_reg);
                        if (CW'(i_reg) == n_last) state_reg <= S_E_START;
                        else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_P_ORD;
                        end
                    end
                end
                S_E_START: begin
                    cur_lg_reg <= lg_reg;
                    i_reg      <= '0;
                    if (total_reg == '0) begin
                        dropped_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end else begin
                        state_reg <= S_E_RD;
                    end
                end
                S_E_RD: state_reg <= S_E_LOAD;
                S_E_LOAD: begin
                    m_valid_reg  <= 1'b1;
                    m_num_reg    <= 6'(i_reg);
                    m_x_reg      <= ok_reg ? pos_rd_reg[12:0] : '0;
                    m_y_reg      <= ok_reg ? pos_rd_reg[25:13] : '0;
                    m_size_reg   <= 14'(size);
                    m_status_reg <= !ok_reg ? gasp_pkg::STATUS_TOO_BIG :
                                    (dropped_reg ? gasp_pkg::STATUS_DROPPED
                                                 : gasp_pkg::STATUS_PLACED);
                    m_last_reg   <= CW'(i_reg) == n_last;
                    state_reg    <= S_E_WAIT;
                end
                S_E_WAIT: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            total_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_E_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_size_reg, m_y_reg, m_x_reg, m_num_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `GASP_ASSERT(a_total_bound, total_reg <= CW'(MAX_GLYPHS), "glyph count above capacity")
    `GASP_ASSERT(a_set_cleared, (m_tvalid && m_tready && m_tlast) |=> (total_reg == '0),
        "set not cleared after final result")
    `GASP_ASSERT(a_fail_zero_pos,
        (m_tvalid && m_tuser == gasp_pkg::STATUS_TOO_BIG) |-> (m_x_reg == '0 && m_y_reg == '0),
        "failed set carries a position")

endmodule

### rtl/glyph_atlas_shelf_packer_core.sv
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_packer_core
// Shelf packer that places a set of glyph rectangles in a square atlas.
// ----------------------------------------------------------------------------
// Glyphs load at one transfer per cycle while the queue has room into a
// four-entry queue and then into the glyph store; tlast ends the set. The
// engine then ranks the n stored glyphs by descending sort height (one store
// read port) and packs them, repeating the pass for each doubling of the
// atlas edge. Results leave in arrival order and wait while the output
// stalls; new glyphs queue up while the engine is busy.

module glyph_atlas_shelf_packer_core #(
    parameter int MAX_GLYPHS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // glyph_width, glyph_height, sort_height
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // glyph_number, pos_x, pos_y, atlas_size
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    logic                  q_valid, q_pop;
    gasp_pkg::glyph_item_t q_item;

    assign cfg_ready = 1'b1;

    gasp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    gasp_back #(
        .MAX_GLYPHS (MAX_GLYPHS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
